@@ hw/rtl/bbh_pkg.sv @@
package bbh_pkg;

	// Default configuration of the filter.
	localparam int DEF_WINDOW_LOG2  = 5;
	localparam int DEF_SAMPLE_WIDTH = 24;

	// Codes of the op field of an input word.
	typedef enum logic [0:0] {
		OP_FILTER = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;

endpackage

@@ hw/rtl/bbh_sample_if.sv @@
interface bbh_sample_if #(
	parameter int SAMPLE_WIDTH = bbh_pkg::DEF_SAMPLE_WIDTH
);
	logic                           valid;
	logic                           ready;
	logic                           op;
	logic signed [SAMPLE_WIDTH-1:0] sample;

	modport source (output valid, output op, output sample, input ready);
	modport sink (input valid, input op, input sample, output ready);
endinterface

@@ hw/rtl/bbh_result_if.sv @@
interface bbh_result_if #(
	parameter int SAMPLE_WIDTH = bbh_pkg::DEF_SAMPLE_WIDTH
);
	logic                         valid;
	logic                         ready;
	logic signed [SAMPLE_WIDTH:0] filtered;

	modport source (output valid, output filtered, input ready);
	modport sink (input valid, input filtered, output ready);
endinterface

@@ hw/rtl/boxcar_baseline_highpass.sv @@
// Path: an accepted word moves into the stage 1 registers, then the output register.
// Throughput: one word per cycle, set by the two-stage pipeline; both stages and the
// output register advance together whenever the output register is empty or drained.
// Reset (arst_n low, asynchronous) clears both delay lines, both running sums and all
// valid flags; a clear op empties lines and sums synchronously, returns a zero word.
module boxcar_baseline_highpass #(
	parameter int WINDOW_LOG2  = bbh_pkg::DEF_WINDOW_LOG2,
	parameter int SAMPLE_WIDTH = bbh_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	bbh_sample_if.sink   sample_ch,
	bbh_result_if.source result_ch
);

	// The window holds 2^WINDOW_LOG2 samples. The running sums need WINDOW_LOG2
	// extra bits over a sample to stay exact.
	localparam int WIN_LEN = 1 << WINDOW_LOG2;
	localparam int SUM_W   = SAMPLE_WIDTH + WINDOW_LOG2;
	localparam int OUT_W   = SAMPLE_WIDTH + 1;

	// The whole pipeline moves as one: it advances whenever the output register
	// is empty or its word is being taken this cycle.
	logic advance;
	logic accept;
	logic out_valid_q;

	assign advance         = !out_valid_q || result_ch.ready;
	assign sample_ch.ready = advance;
	assign accept          = sample_ch.valid && advance;

	// Stage 1: the sample delay line and the first running sum. The delay line
	// holds the previous WIN_LEN samples; its last tap is the sample that leaves
	// the window now, which is also the delayed sample for the output.
	logic signed [SAMPLE_WIDTH-1:0] sample_line_q [WIN_LEN];
	logic signed [SUM_W-1:0]        first_sum_q;
	logic signed [SUM_W-1:0]        first_sum_next;
	logic signed [SAMPLE_WIDTH-1:0] delayed_s1;
	logic                           valid_s1;
	logic                           clear_s1;
	logic                           op_clear;

	assign op_clear = (sample_ch.op == bbh_pkg::OP_CLEAR);

	// Modular arithmetic at SUM_W bits is exact because the true sum always fits.
	assign first_sum_next = first_sum_q
		+ SUM_W'(sample_ch.sample)
		- SUM_W'(sample_line_q[WIN_LEN-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_LEN; i++) begin
				sample_line_q[i] <= '0;
			end
			first_sum_q <= '0;
		end else if (accept) begin
			if (op_clear) begin
				for (int i = 0; i < WIN_LEN; i++) begin
					sample_line_q[i] <= '0;
				end
				first_sum_q <= '0;
			end else begin
				sample_line_q[0] <= sample_ch.sample;
				for (int i = 1; i < WIN_LEN; i++) begin
					sample_line_q[i] <= sample_line_q[i-1];
				end
				first_sum_q <= first_sum_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			clear_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= sample_ch.valid;
			clear_s1 <= op_clear;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			delayed_s1 <= sample_line_q[WIN_LEN-1];
		end
	end

	// Stage 2: the first mean is the floor of the registered sum over the window,
	// an arithmetic right shift. It enters the second delay line and running sum,
	// and the twice-smoothed mean is subtracted from the delayed sample.
	logic signed [SAMPLE_WIDTH-1:0] mean_line_q [WIN_LEN];
	logic signed [SUM_W-1:0]        second_sum_q;
	logic signed [SUM_W-1:0]        second_sum_next;
	logic signed [SUM_W-1:0]        first_mean_full;
	logic signed [SAMPLE_WIDTH-1:0] first_mean;
	logic signed [SUM_W-1:0]        second_mean_full;
	logic signed [SAMPLE_WIDTH-1:0] second_mean;
	logic signed [OUT_W-1:0]        difference;
	logic signed [OUT_W-1:0]        filtered_q;
	logic                           take_s1;

	assign take_s1          = valid_s1 && advance;
	assign first_mean_full  = first_sum_q >>> WINDOW_LOG2;
	assign first_mean       = first_mean_full[SAMPLE_WIDTH-1:0];
	assign second_sum_next  = second_sum_q
		+ SUM_W'(first_mean)
		- SUM_W'(mean_line_q[WIN_LEN-1]);
	assign second_mean_full = second_sum_next >>> WINDOW_LOG2;
	assign second_mean      = second_mean_full[SAMPLE_WIDTH-1:0];
	assign difference       = OUT_W'(delayed_s1) - OUT_W'(second_mean);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_LEN; i++) begin
				mean_line_q[i] <= '0;
			end
			second_sum_q <= '0;
		end else if (take_s1) begin
			if (clear_s1) begin
				for (int i = 0; i < WIN_LEN; i++) begin
					mean_line_q[i] <= '0;
				end
				second_sum_q <= '0;
			end else begin
				mean_line_q[0] <= first_mean;
				for (int i = 1; i < WIN_LEN; i++) begin
					mean_line_q[i] <= mean_line_q[i-1];
				end
				second_sum_q <= second_sum_next;
			end
		end
	end

	// Output register: it holds its word until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			filtered_q <= clear_s1 ? '0 : difference;
		end
	end

	assign result_ch.valid    = out_valid_q;
	assign result_ch.filtered = filtered_q;

	// A clear word leaves a zero result behind it.
	assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 && clear_s1 |=> out_valid_q && filtered_q == '0)
		else $error("clear word did not give a zero result");

	// A clear accepted at stage 1 empties the first running sum.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && op_clear |=> first_sum_q == '0)
		else $error("first running sum not cleared");

	// While the output is stalled, a word in stage 1 stays there.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(delayed_s1) && $stable(first_sum_q))
		else $error("stage 1 word lost during a stall");

	// Every word that leaves stage 1 shows up in the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 |=> out_valid_q)
		else $error("stage 1 word did not reach the output register");

endmodule

@@ dv/highpass_score_pkg.sv @@
`timescale 1ns / 100ps

package highpass_score_pkg;

	import bbh_pkg::*;

	localparam int WIN_LOG2   = DEF_WINDOW_LOG2;
	localparam int SW         = DEF_SAMPLE_WIDTH;
	localparam int RING_DEPTH = (1 << WIN_LOG2) + 1;

	typedef logic signed [SW-1:0] sample_t;
	typedef logic signed [SW:0]   filtered_t;

	// Mirrors the two boxcar stages and keeps the filtered words still owed.
	class highpass_score;
		sample_t   sample_ring [RING_DEPTH];
		sample_t   mean_ring [RING_DEPTH];
		longint    sample_sum;
		longint    mean_sum;
		int        slot;
		filtered_t filtered_due [$];
		int        bad_words;

		function new();
			bad_words = 0;
			wipe();
		endfunction

		function void wipe();
			foreach (sample_ring[i]) begin
				sample_ring[i] = '0;
				mean_ring[i]   = '0;
			end
			sample_sum = 0;
			mean_sum   = 0;
			slot       = 0;
		endfunction

		function void note_sample(op_t op, sample_t value);
			int        oldest;
			sample_t   first_mean;
			sample_t   second_mean;
			filtered_t want;
			if (op == OP_CLEAR) begin
				wipe();
				filtered_due.push_back('0);
				return;
			end
			oldest = (slot == RING_DEPTH - 1) ? 0 : slot + 1;
			sample_ring[slot] = value;
			sample_sum += longint'(value) - longint'(sample_ring[oldest]);
			// An arithmetic shift of the signed sum floors towards minus infinity.
			first_mean = SW'(sample_sum >>> WIN_LOG2);
			mean_ring[slot] = first_mean;
			mean_sum += longint'(first_mean) - longint'(mean_ring[oldest]);
			second_mean = SW'(mean_sum >>> WIN_LOG2);
			want = (SW+1)'(longint'(sample_ring[oldest]) - longint'(second_mean));
			slot = oldest;
			filtered_due.push_back(want);
		endfunction

		function void check_filtered(filtered_t got);
			filtered_t want;
			if (filtered_due.size() == 0) begin
				if (bad_words < 10)
					$display("filtered word %0d arrived with nothing pending", got);
				bad_words++;
				return;
			end
			want = filtered_due.pop_front();
			if (got !== want) begin
				if (bad_words < 10)
					$display("filtered mismatch: expected %0d, got %0d", want, got);
				bad_words++;
			end
		endfunction

		function int pending();
			return filtered_due.size();
		endfunction
	endclass

endpackage

@@ dv/tb_boxcar_baseline_highpass.sv @@
`timescale 1ns / 100ps

module tb_boxcar_baseline_highpass;

	import bbh_pkg::*;
	import highpass_score_pkg::*;

	localparam sample_t SAMPLE_MAX  = {1'b0, {(SW-1){1'b1}}};
	localparam sample_t SAMPLE_MIN  = {1'b1, {(SW-1){1'b0}}};
	// Longest stretch without any word moving on either side before the run
	// is declared hung, longer than any sender gap or receiver stall.
	localparam int      QUIET_LIMIT = 2000;

	logic clk;
	logic arst_n;

	bbh_sample_if sample_ch ();
	bbh_result_if result_ch ();

	boxcar_baseline_highpass u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch)
	);

	highpass_score score = new();

	// When set, neither side inserts gaps, so the pipeline runs at full rate.
	bit     steady = 1'b0;
	// Slowly wandering level that stands in for an ECG baseline.
	longint drift  = 0;
	int     quiet  = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Mostly no gap, often a short one, now and then a long one.
	function int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Produces the idx-th sample of a run of the given flavor. The flavors
	// cover the whole field, a drifting baseline with spikes, long constant
	// runs at both extremes (which drive the running sums to their limits),
	// alternating extremes, and tiny values that exercise rounding of
	// negative means.
	function sample_t shaped_sample(int kind, int idx);
		longint v;
		case (kind)
			0: begin
				v = longint'(sample_t'($urandom));
			end
			1: begin
				drift += longint'($urandom_range(0, 40000)) - 20000;
				if (drift > 7000000)
					drift = 7000000;
				if (drift < -7000000)
					drift = -7000000;
				v = drift + longint'($urandom_range(0, 4000)) - 2000;
				if (idx % 25 == 0)
					v += 600000;
			end
			2: begin
				v = longint'(SAMPLE_MAX);
			end
			3: begin
				v = longint'(SAMPLE_MIN);
			end
			4: begin
				v = idx[0] ? longint'(SAMPLE_MAX) : longint'(SAMPLE_MIN);
			end
			default: begin
				v = longint'($urandom_range(0, 6)) - 3;
			end
		endcase
		return sample_t'(v);
	endfunction

	// Presents one word after a random gap and returns at the edge that
	// accepts it. Valid is only lowered when a gap is actually inserted, so a
	// back-to-back word never sees valid dropped and raised in one step.
	task automatic send_word(op_t op, sample_t value);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid  <= 1'b1;
		sample_ch.op     <= op;
		sample_ch.sample <= value;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
	endtask

	// Result side: ready is raised between random stalls and stays high while no stall is drawn.
	initial begin : drain
		int stall;
		result_ch.ready = 1'b0;
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Both handshakes are sampled at the clock edge. Inputs are noted before
	// results are checked, so even a result in the same cycle as its input would
	// find its expectation. The same block watches for a stalled run.
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready)
				score.note_sample(op_t'(sample_ch.op), sample_ch.sample);
			if (result_ch.valid && result_ch.ready)
				score.check_filtered(result_ch.filtered);
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int sent;
		int run_len;
		int kind;
		int k;
		bit pressed;
		sample_ch.valid  = 1'b0;
		sample_ch.op     = OP_FILTER;
		sample_ch.sample = '0;
		arst_n           = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: field extremes straight out of reset, so the zero
		// history of warm-up is part of every sum.
		send_word(OP_FILTER, SAMPLE_MIN);
		send_word(OP_FILTER, SAMPLE_MAX);
		send_word(OP_FILTER, '0);
		send_word(OP_FILTER, sample_t'(-1));
		send_word(OP_FILTER, sample_t'(1));
		// A clear in the middle of warm-up must zero the result and history.
		send_word(OP_CLEAR, SAMPLE_MAX);
		for (k = 0; k < 8; k++)
			send_word(OP_FILTER, SAMPLE_MAX);
		for (k = 0; k < 8; k++)
			send_word(OP_FILTER, SAMPLE_MIN);
		send_word(OP_CLEAR, SAMPLE_MIN);
		// A lone -1 gives a sum of -1, whose mean must floor to -1, not 0.
		send_word(OP_FILTER, sample_t'(-1));
		send_word(OP_FILTER, sample_t'(1));

		// Random part: runs of 20 to 150 words, most long enough to fill both
		// rings, each of one flavor, some at full rate, with clears between some
		// of them. Short runs followed by a clear break off the warm-up.
		sent    = 0;
		pressed = 1'b0;
		while (sent < 900) begin
			run_len = $urandom_range(20, 150);
			if (run_len > 900 - sent)
				run_len = 900 - sent;
			kind    = $urandom_range(0, 5);
			steady  = ($urandom_range(0, 3) == 0);
			for (k = 0; k < run_len; k++)
				send_word(OP_FILTER, shaped_sample(kind, k));
			sent += run_len;
			if ($urandom_range(0, 2) == 0) begin
				send_word(OP_CLEAR, sample_t'($urandom));
				sent++;
			end
			// Once, halfway, let the pipeline drain completely before going on.
			if (!pressed && sent >= 450) begin
				pressed = 1'b1;
				steady  = 1'b0;
				sample_ch.valid <= 1'b0;
				@(posedge clk);
				while (score.pending() != 0)
					@(posedge clk);
			end
		end
		steady = 1'b0;
		sample_ch.valid <= 1'b0;

		// Wait for the last results, then run on idle so that any
		// stray word from the two-stage pipeline is caught.
		@(posedge clk);
		while (score.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (score.bad_words == 0 && score.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
